@@ src/gmcp_pkg.sv @@
`timescale 1ns / 1ps
package gmcp_pkg;
   localparam int MaxRowsDef = 8;
   localparam int MaxColsDef = 8;
   localparam int CostW = 32;
   localparam int DistW = 38;
   localparam int SizeW = 4;
   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;
endpackage

@@ src/gmcp_if.sv @@
`timescale 1ns / 1ps
interface gmcp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] cell_cost;
   logic        is_last_cell;
   modport source (output valid, cell_cost, is_last_cell, input ready);
   modport sink (input valid, cell_cost, is_last_cell, output ready);
endinterface

interface gmcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] path_column;
   logic       path_end;
   modport source (output valid, path_column, path_end, input ready);
   modport sink (input valid, path_column, path_end, output ready);
endinterface

interface gmcp_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [3:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/grid_min_cost_path_spfa_top.sv @@
`timescale 1ns / 1ps
// Load: one cell item per cycle; ready is low during search and output.
// Search: a clearing pass over all MAX_ROWS*MAX_COLS+2 nodes, then FIFO relaxation on one shared
// adder/compare: a pop runs FRD then POP, a relaxation NB, RD then CMP, a skipped neighbor or row NB.
// Output: predecessor walk through WALK and WRD, where WRD reduces each path cell to its column,
// then path items one per cycle while rsp.ready does not hold them.
// Reset: synchronous, active high; sizes reset to 8, load index to zero.
module grid_min_cost_path_spfa_top
   import gmcp_pkg::*;
#(
   parameter int MAX_ROWS = MaxRowsDef,
   parameter int MAX_COLS = MaxColsDef
) (
   input logic clock,
   input logic reset,
   gmcp_req_if.sink req,
   gmcp_rsp_if.source rsp,
   gmcp_csr_if.sink csr
);
   localparam int Cells = MAX_ROWS * MAX_COLS;
   localparam int Nodes = Cells + 2;
   localparam int NW = $clog2(Nodes);
   localparam int CW = $clog2(Cells);
   localparam int PW = $clog2(Cells + 1);

   typedef enum logic [3:0] {
      S_LOAD, S_CLR, S_FRD, S_POP, S_NB, S_RD, S_CMP, S_WALK, S_WRD, S_OUT
   } state_type;

   state_type state_ff;
   logic [SizeW-1:0] rows_ff, cols_ff;
   logic [NW-1:0] ld_ff, cnt_ff, u_ff, to_ff, head_ff, fcnt_ff, v_ff, cells_ff;
   logic [NW-1:0] r_ff, c_ff;
   logic [1:0] nb_ff;
   logic [CostW-1:0] cost_mem [Cells];
   logic [DistW-1:0] dist_mem [Nodes];
   logic [NW-1:0] pred_mem [Nodes];
   logic [NW-1:0] fifo_mem [Nodes];
   logic [2:0] stack_mem [Cells];
   logic [Nodes-1:0] reach_ff, queue_ff;
   logic [DistW-1:0] du_ff, dt_ff, cand_ff;
   logic [CostW-1:0] w_ff;
   logic [NW-1:0] fifo_rd_ff, pred_rd_ff;
   logic [PW-1:0] depth_ff, oj_ff;
   logic [2:0] stk_rd_ff;
   logic rsp_v_ff;
   logic [3:0] rsp_col_ff;
   logic rsp_end_ff;

   logic [SizeW-1:0] rows_c, cols_c;
   assign rows_c = (rows_ff == 0) ? 4'd1 :
      (rows_ff > SizeW'(MAX_ROWS)) ? SizeW'(MAX_ROWS) : rows_ff;
   assign cols_c = (cols_ff == 0) ? 4'd1 :
      (cols_ff > SizeW'(MAX_COLS)) ? SizeW'(MAX_COLS) : cols_ff;
   logic [NW-1:0] ncells;
   assign ncells = NW'(rows_c) * NW'(cols_c);

   logic [NW-1:0] rows_n, cols_n;
   assign rows_n = NW'(rows_c);
   assign cols_n = NW'(cols_c);
   logic [NW-1:0] sink_n;
   assign sink_n = cells_ff + 1'b1;

   assign req.ready = (state_ff == S_LOAD);
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_v_ff;
   assign rsp.path_column = rsp_col_ff;
   assign rsp.path_end = rsp_end_ff;

   logic [NW:0] tail_sum;
   logic [NW-1:0] tail;
   always_comb begin
      tail_sum = {1'b0, head_ff} + {1'b0, fcnt_ff};
      if (tail_sum >= (NW+1)'(Nodes)) tail_sum = tail_sum - (NW+1)'(Nodes);
      tail = tail_sum[NW-1:0];
   end

   logic [PW-1:0] oj_rd;
   assign oj_rd = (state_ff != S_OUT) ? '0 :
      (!rsp_v_ff || rsp.ready) ? oj_ff + 1'b1 : oj_ff;

   // neighbor select: 0 sink, 1 right, 2 down, 3 left; source handles columns
   logic nb_ok;
   logic [NW-1:0] nb_to;
   logic [CW-1:0] nb_cell;
   always_comb begin
      nb_ok = 1'b0;
      nb_to = '0;
      nb_cell = '0;
      if (u_ff == 0) begin
         nb_ok = 1'b1;
         nb_to = c_ff + 1'b1;
         nb_cell = CW'(c_ff);
      end else begin
         case (nb_ff)
            2'd0: begin
               nb_ok = (r_ff == rows_n - 1'b1);
               nb_to = sink_n;
            end
            2'd1: begin
               nb_ok = (c_ff + 1'b1 < cols_n);
               nb_to = u_ff + 1'b1;
               nb_cell = CW'(u_ff);
            end
            2'd2: begin
               nb_ok = (r_ff + 1'b1 < rows_n);
               nb_to = u_ff + cols_n;
               nb_cell = CW'(u_ff - 1'b1 + cols_n);
            end
            default: begin
               nb_ok = (c_ff != 0);
               nb_to = u_ff - 1'b1;
               nb_cell = CW'(u_ff - 2'd2);
            end
         endcase
      end
   end

   logic nb_last;
   assign nb_last = (u_ff == 0) ? (c_ff == 0) : (nb_ff == 2'd3);

   always_ff @(posedge clock) begin
      fifo_rd_ff <= fifo_mem[head_ff];
      pred_rd_ff <= pred_mem[v_ff];
      stk_rd_ff <= stack_mem[CW'(depth_ff - 1'b1 - oj_rd)];
      du_ff <= dist_mem[u_ff];
      dt_ff <= dist_mem[to_ff];
      w_ff <= cost_mem[nb_cell];
      if (reset) begin
         state_ff <= S_LOAD;
         rows_ff <= 4'd8;
         cols_ff <= 4'd8;
         ld_ff <= '0;
         rsp_v_ff <= 1'b0;
         reach_ff <= '0;
         queue_ff <= '0;
         head_ff <= '0;
         fcnt_ff <= '0;
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_ROWS) rows_ff <= csr.data;
            else if (csr.index == CSR_COLS) cols_ff <= csr.data;
         end
         if (state_ff != S_OUT && rsp_v_ff && rsp.ready) rsp_v_ff <= 1'b0;
         case (state_ff)
            S_LOAD: if (req.valid) begin
               if (ld_ff < ncells) begin
                  cost_mem[CW'(ld_ff)] <= req.cell_cost;
                  ld_ff <= ld_ff + 1'b1;
               end
               if (req.is_last_cell) begin
                  cells_ff <= ncells;
                  cnt_ff <= '0;
                  state_ff <= S_CLR;
               end
            end
            S_CLR: begin
               dist_mem[cnt_ff] <= '0;
               reach_ff <= Nodes'(1);
               queue_ff <= Nodes'(1);
               if (cnt_ff == NW'(Nodes - 1)) begin
                  fifo_mem[0] <= '0;
                  head_ff <= '0;
                  fcnt_ff <= NW'(1);
                  state_ff <= S_FRD;
               end
               cnt_ff <= cnt_ff + 1'b1;
            end
            S_FRD: state_ff <= S_POP;
            S_POP: begin
               if (fcnt_ff == 0) begin
                  v_ff <= pred_mem[sink_n];
                  depth_ff <= '0;
                  state_ff <= S_WALK;
               end else begin
                  u_ff <= fifo_rd_ff;
                  queue_ff[fifo_rd_ff] <= 1'b0;
                  head_ff <= (head_ff == NW'(Nodes - 1)) ? '0 : head_ff + 1'b1;
                  fcnt_ff <= fcnt_ff - 1'b1;
                  nb_ff <= '0;
                  if (fifo_rd_ff == 0) begin
                     c_ff <= cols_n - 1'b1;
                     state_ff <= S_NB;
                  end else if (fifo_rd_ff <= cells_ff) begin
                     r_ff <= '0;
                     c_ff <= fifo_rd_ff - 1'b1;
                     state_ff <= S_NB;
                  end else begin
                     state_ff <= S_FRD;
                  end
               end
            end
            S_NB: begin
               // reduce cell index to row/col by repeated subtraction
               if (u_ff != 0 && c_ff >= cols_n) begin
                  c_ff <= c_ff - cols_n;
                  r_ff <= r_ff + 1'b1;
               end else if (nb_ok) begin
                  to_ff <= nb_to;
                  state_ff <= S_RD;
               end else if (nb_last) begin
                  state_ff <= S_FRD;
               end else begin
                  nb_ff <= nb_ff + 1'b1;
               end
            end
            S_RD: begin
               cand_ff <= (u_ff == 0 || nb_ff != 0) ? DistW'(w_ff) : '0;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (!reach_ff[to_ff] || dt_ff > du_ff + cand_ff) begin
                  dist_mem[to_ff] <= du_ff + cand_ff;
                  reach_ff[to_ff] <= 1'b1;
                  pred_mem[to_ff] <= u_ff;
                  if (!queue_ff[to_ff]) begin
                     queue_ff[to_ff] <= 1'b1;
                     fifo_mem[tail] <= to_ff;
                     fcnt_ff <= fcnt_ff + 1'b1;
                  end
               end
               if (nb_last) state_ff <= S_FRD;
               else begin
                  if (u_ff == 0) c_ff <= c_ff - 1'b1;
                  else nb_ff <= nb_ff + 1'b1;
                  state_ff <= S_NB;
               end
            end
            S_WALK: begin
               if (depth_ff < PW'(Cells) && v_ff >= 1 && v_ff <= cells_ff) begin
                  cnt_ff <= v_ff - 1'b1;
                  state_ff <= S_WRD;
               end else begin
                  oj_ff <= '0;
                  ld_ff <= '0;
                  state_ff <= (depth_ff == 0) ? S_LOAD : S_OUT;
               end
            end
            S_WRD: begin
               if (cnt_ff >= cols_n) cnt_ff <= cnt_ff - cols_n;
               else begin
                  stack_mem[CW'(depth_ff)] <= 3'(cnt_ff);
                  depth_ff <= depth_ff + 1'b1;
                  if (pred_rd_ff == 0) begin
                     v_ff <= '0;
                  end else v_ff <= pred_rd_ff;
                  state_ff <= S_WALK;
               end
            end
            S_OUT: begin
               if (!rsp_v_ff || rsp.ready) begin
                  rsp_v_ff <= 1'b1;
                  rsp_col_ff <= {1'b0, stk_rd_ff} + 4'd1;
                  rsp_end_ff <= (oj_ff == depth_ff - 1'b1);
                  oj_ff <= oj_ff + 1'b1;
                  if (oj_ff == depth_ff - 1'b1) state_ff <= S_LOAD;
                  else state_ff <= S_OUT;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp.ready |=> rsp_v_ff)
      else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> to_ff <= cells_ff + 1'b1)
      else $error("relax target out of range");
   assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= NW'(Nodes))
      else $error("work queue overflow");
endmodule

@@ tb/grid_min_cost_path_spfa_top_tb.sv @@
`timescale 1ns / 1ps
module grid_min_cost_path_spfa_top_tb;
   import gmcp_pkg::*;

   localparam int GridMax = MaxRowsDef * MaxColsDef;
   localparam int NodeMax = GridMax + 2;
   localparam int StallLimit = 200000;
   localparam int SettleCycles = 40;

   typedef struct {
      logic [SizeW-1:0] path_column;
      logic             path_end;
   } path_item_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gmcp_req_if req ();
   gmcp_rsp_if rsp ();
   gmcp_csr_if csr ();

   grid_min_cost_path_spfa_top DUT (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [CostW-1:0] cost_mem [GridMax];
   int               pred_node [NodeMax];
   int               load_idx;
   logic [SizeW-1:0] rows_reg;
   logic [SizeW-1:0] cols_reg;
   path_item_t       expected_path [$];
   int               errors;
   int               items_sent;
   bit               calm;
   int               stall_count;

   function automatic int clamp_size(logic [SizeW-1:0] v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic search_path();
      int          rows;
      int          cols;
      int          cells;
      int          sink;
      longint      node_dist [NodeMax];
      bit          reached [NodeMax];
      bit          queued [NodeMax];
      int          work [$];
      int          cols_on_path [$];
      int          u;
      int          v;
      int          r;
      int          c;
      int          to_node [4];
      longint      wt [4];
      int          nto;
      longint      cand;
      path_item_t  item;
      rows = clamp_size(rows_reg, MaxRowsDef);
      cols = clamp_size(cols_reg, MaxColsDef);
      cells = rows * cols;
      sink = cells + 1;
      for (int i = 0; i < NodeMax; i++) begin
         node_dist[i] = 0;
         reached[i] = 0;
         queued[i] = 0;
      end
      reached[0] = 1;
      queued[0] = 1;
      work.push_back(0);
      while (work.size() > 0) begin
         u = work.pop_front();
         queued[u] = 0;
         nto = 0;
         if (u == 0) begin
            for (int k = cols - 1; k >= 0; k--) begin
               to_node[0] = k + 1;
               wt[0] = cost_mem[k];
               cand = node_dist[0] + wt[0];
               if (!reached[k + 1] || node_dist[k + 1] > cand) begin
                  node_dist[k + 1] = cand;
                  reached[k + 1] = 1;
                  pred_node[k + 1] = 0;
                  if (!queued[k + 1]) begin
                     work.push_back(k + 1);
                     queued[k + 1] = 1;
                  end
               end
            end
         end else if (u <= cells) begin
            r = (u - 1) / cols;
            c = (u - 1) % cols;
            if (r == rows - 1) begin
               to_node[nto] = sink; wt[nto] = 0; nto++;
            end
            if (c + 1 < cols) begin
               to_node[nto] = u + 1; wt[nto] = cost_mem[u]; nto++;
            end
            if (r + 1 < rows) begin
               to_node[nto] = u + cols; wt[nto] = cost_mem[u - 1 + cols]; nto++;
            end
            if (c > 0) begin
               to_node[nto] = u - 1; wt[nto] = cost_mem[u - 2]; nto++;
            end
            for (int k = 0; k < nto; k++) begin
               cand = node_dist[u] + wt[k];
               if (!reached[to_node[k]] || node_dist[to_node[k]] > cand) begin
                  node_dist[to_node[k]] = cand;
                  reached[to_node[k]] = 1;
                  pred_node[to_node[k]] = u;
                  if (!queued[to_node[k]]) begin
                     work.push_back(to_node[k]);
                     queued[to_node[k]] = 1;
                  end
               end
            end
         end
      end
      v = pred_node[sink];
      while (cols_on_path.size() < GridMax && v >= 1 && v <= cells) begin
         cols_on_path.push_back((v - 1) % cols);
         if (pred_node[v] == 0) break;
         v = pred_node[v];
      end
      for (int j = cols_on_path.size() - 1; j >= 0; j--) begin
         item.path_column = SizeW'(cols_on_path[j] + 1);
         item.path_end = (j == 0);
         expected_path.push_back(item);
      end
   endtask

   task automatic predict_cell(logic [CostW-1:0] cost, logic last);
      int cells;
      cells = clamp_size(rows_reg, MaxRowsDef) * clamp_size(cols_reg, MaxColsDef);
      if (load_idx < cells) begin
         cost_mem[load_idx] = cost;
         load_idx++;
      end
      if (last) begin
         search_path();
         load_idx = 0;
      end
   endtask

   task automatic send_cell(logic [CostW-1:0] cost, logic last);
      while (!calm && $urandom_range(99) < 13) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.cell_cost <= cost;
      req.is_last_cell <= last;
      do @(posedge clock); while (!req.ready);
      predict_cell(cost, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_path.size() > 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [SizeW-1:0] value);
      drain();
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      if (idx == CSR_ROWS) rows_reg = value;
      else cols_reg = value;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   function automatic logic [CostW-1:0] pick_cost();
      case ($urandom_range(5))
         0: return '1;
         1: return $urandom_range(9);
         2: return CostW'($urandom_range(1000));
         default: return $urandom;
      endcase
   endfunction

   task automatic send_grid(int extra, bit fixed, logic [CostW-1:0] fill);
      int n;
      n = clamp_size(rows_reg, MaxRowsDef) * clamp_size(cols_reg, MaxColsDef) + extra;
      for (int i = 0; i < n; i++) send_cell(fixed ? fill : pick_cost(), i == n - 1);
   endtask

   task automatic test_default_size();
      send_grid(0, 0, '0);
      drain();
   endtask

   task automatic test_extremes();
      write_csr(CSR_ROWS, 4'd1);
      write_csr(CSR_COLS, 4'd1);
      send_grid(0, 1, '0);
      send_grid(0, 1, '1);
      write_csr(CSR_ROWS, 4'd2);
      write_csr(CSR_COLS, 4'd2);
      send_grid(0, 1, '1);
      send_cell(32'hFFFF_FFFF, 1'b0);
      send_cell(32'h0, 1'b0);
      send_cell(32'h0, 1'b0);
      send_cell(32'hFFFF_FFFF, 1'b1);
      write_csr(CSR_ROWS, 4'd0);
      write_csr(CSR_COLS, 4'd15);
      send_grid(0, 0, '0);
      write_csr(CSR_ROWS, 4'd9);
      write_csr(CSR_COLS, 4'd0);
      send_grid(0, 0, '0);
   endtask

   task automatic test_extra_cells();
      write_csr(CSR_ROWS, 4'd2);
      write_csr(CSR_COLS, 4'd3);
      send_grid(3, 0, '0);
      send_grid(1, 0, '0);
   endtask

   task automatic test_random_grids();
      int goal;
      goal = items_sent + 264;
      while (items_sent < goal) begin
         if ($urandom_range(99) < 85) begin
            write_csr(CSR_ROWS, SizeW'($urandom_range(1, 4)));
            write_csr(CSR_COLS, SizeW'($urandom_range(1, 4)));
         end else begin
            write_csr(CSR_ROWS, SizeW'($urandom_range(15)));
            write_csr(CSR_COLS, SizeW'($urandom_range(15)));
         end
         calm = ($urandom_range(99) < 20);
         repeat ($urandom_range(1, 3))
            send_grid(($urandom_range(99) < 10) ? $urandom_range(1, 3) : 0, 0, '0);
         calm = 0;
      end
      drain();
   endtask

   always @(negedge clock) rsp.ready <= calm || ($urandom_range(99) >= 13);

   always @(posedge clock) begin
      path_item_t exp_item;
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= StallLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_path.size() == 0) begin
            $error("unexpected item: path_column %0d path_end %0d",
                   rsp.path_column, rsp.path_end);
            errors++;
         end else begin
            exp_item = expected_path.pop_front();
            if (rsp.path_column !== exp_item.path_column) begin
               $error("path_column expected %0d actual %0d",
                      exp_item.path_column, rsp.path_column);
               errors++;
            end
            if (rsp.path_end !== exp_item.path_end) begin
               $error("path_end expected %0d actual %0d", exp_item.path_end, rsp.path_end);
               errors++;
            end
         end
      end
   end

   initial begin
      req.valid = 1'b0;
      req.cell_cost = '0;
      req.is_last_cell = 1'b0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      items_sent = 0;
      calm = 0;
      load_idx = 0;
      rows_reg = 4'd8;
      cols_reg = 4'd8;
      for (int i = 0; i < NodeMax; i++) pred_node[i] = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_size();
      test_extremes();
      test_extra_cells();
      test_random_grids();
      if (expected_path.size() != 0)
         $error("%0d expected items never arrived", expected_path.size());
      if (errors == 0 && expected_path.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
